[src/tds_pkg.sv]
package tds_pkg;

	typedef struct packed {
		logic lt;
		logic qm;
		logic eq;
		logic gt;
		logic w;
		logic c;
		logic space;
		logic cr;
		logic nl;
		logic lbrace;
		logic rbrace;
		logic slash;
		logic star;
		logic dquote;
	} cls_t;

	localparam logic       CMD_BYTE  = 1'b0;
	localparam logic       CMD_END   = 1'b1;

	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_CSTR = 2'd1;
	localparam logic [1:0] KIND_CODE = 2'd2;

	localparam int         QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_QM     = 8'h3F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_W      = 8'h77;
	localparam logic [7:0] CH_C      = 8'h63;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	function automatic cls_t classify(input logic [7:0] b);
		cls_t r;
		r.lt     = (b == CH_LT);
		r.qm     = (b == CH_QM);
		r.eq     = (b == CH_EQ);
		r.gt     = (b == CH_GT);
		r.w      = (b == CH_W);
		r.c      = (b == CH_C);
		r.space  = (b == CH_SP) || (b == CH_TAB) || (b == CH_NL);
		r.cr     = (b == CH_CR);
		r.nl     = (b == CH_NL);
		r.lbrace = (b == CH_LBRACE);
		r.rbrace = (b == CH_RBRACE);
		r.slash  = (b == CH_SLASH);
		r.star   = (b == CH_STAR);
		r.dquote = (b == CH_DQUOTE);
		return r;
	endfunction

endpackage

[src/tds_stream_if.sv]
interface tds_byte_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] byte_value;

	modport source(output valid, command, byte_value, input ready);
	modport sink(input valid, command, byte_value, output ready);
endinterface

interface tds_block_if;
	logic        valid;
	logic        ready;
	logic [1:0]  block_kind;
	logic [31:0] block_start;
	logic [31:0] block_end;
	logic [15:0] block_scope;
	logic        quick_print;

	modport source(output valid, block_kind, block_start, block_end, block_scope,
		quick_print, input ready);
	modport sink(input valid, block_kind, block_start, block_end, block_scope,
		quick_print, output ready);
endinterface

[src/tds_front.sv]
module tds_front #(
	parameter int OFFSET_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tds_byte_if.sink               bytes,
	input  logic                   full,
	output logic                   push,
	output logic                   cmd,
	output tds_pkg::cls_t          cls,
	output logic [OFFSET_BITS-1:0] off
);
	import tds_pkg::*;

	logic [OFFSET_BITS-1:0] off_q;

	assign bytes.ready = !full;
	assign push        = bytes.valid && !full;
	assign cmd         = bytes.command;
	assign cls         = classify(bytes.byte_value);
	assign off         = off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (push) begin
			if (bytes.command == CMD_END) begin
				off_q <= '0;
			end else begin
				off_q <= off_q + 1'b1;
			end
		end
	end
endmodule

[src/tds_queue.sv]
module tds_queue #(
	parameter int WIDTH = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);
	import tds_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   count_q;
	logic             do_pop;

	assign full   = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign valid  = (count_q != '0);
	assign rdata  = mem[rd_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue written while full");
endmodule

[src/tds_back.sv]
module tds_back #(
	parameter int OFFSET_BITS = 32,
	parameter int DEPTH_BITS  = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   valid,
	input  logic                   cmd,
	input  tds_pkg::cls_t          cls,
	input  logic [OFFSET_BITS-1:0] off,
	output logic                   pop,
	tds_block_if.source            blocks
);
	import tds_pkg::*;

	localparam logic [2:0] STEP0 = 3'd0;
	localparam logic [2:0] STEP1 = 3'd1;
	localparam logic [2:0] STEP2 = 3'd2;
	localparam logic [2:0] STEP3 = 3'd3;
	localparam logic [2:0] STEP4 = 3'd4;

	typedef struct packed {
		logic                   code;
		logic                   line;
		logic                   blk;
		logic                   str;
		logic                   cms;
		logic [2:0]             step;
		logic [OFFSET_BITS-1:0] rstart;
		logic [OFFSET_BITS-1:0] dstart;
		logic                   skip;
		logic [DEPTH_BITS-1:0]  brace;
		logic                   quick;
		logic                   ncs;
	} st_t;

	localparam st_t ST_RESET = '0;
	localparam logic [DEPTH_BITS-1:0] BRACE_MAX = '1;

	st_t                    st_q;
	st_t                    nxt;
	logic                   emit;
	logic [1:0]             e_kind;
	logic [OFFSET_BITS-1:0] e_start;
	logic [OFFSET_BITS-1:0] e_end;
	logic [DEPTH_BITS-1:0]  e_scope;
	logic                   e_qp;
	logic                   adv;
	logic [OFFSET_BITS-1:0] off_inc;
	logic                   end_region;
	logic                   open_code;

	assign adv     = valid && (!blocks.valid || blocks.ready);
	assign pop     = adv;
	assign off_inc = off + 1'b1;

	always_comb begin
		nxt        = st_q;
		emit       = 1'b0;
		e_kind     = KIND_ECHO;
		e_start    = st_q.rstart;
		e_end      = st_q.dstart;
		e_scope    = st_q.brace;
		e_qp       = 1'b0;
		end_region = 1'b0;
		open_code  = 1'b0;
		if (cmd == CMD_END) begin
			if (st_q.rstart != off) begin
				emit   = 1'b1;
				e_kind = st_q.code ? KIND_CODE : KIND_ECHO;
				e_end  = off;
			end
			nxt = ST_RESET;
		end else if (!cls.cr) begin
			if (st_q.skip && cls.nl) begin
				nxt.skip   = 1'b0;
				nxt.rstart = off_inc;
			end else begin
				nxt.skip = 1'b0;
				if (st_q.code) begin
					if (st_q.line) begin
						if (cls.nl) begin
							nxt.line = 1'b0;
						end
					end else begin
						if (!st_q.str) begin
							if (!st_q.blk) begin
								if (cls.lbrace && st_q.brace != BRACE_MAX) begin
									nxt.brace = st_q.brace + 1'b1;
								end
								if (cls.rbrace && st_q.brace != '0) begin
									nxt.brace = st_q.brace - 1'b1;
								end
								if (!st_q.cms) begin
									if (cls.slash) begin
										nxt.cms = 1'b1;
									end
								end else begin
									if (cls.star) begin
										nxt.blk = 1'b1;
									end
									if (cls.slash) begin
										nxt.line = 1'b1;
									end
									nxt.cms = 1'b0;
								end
								case (st_q.step)
									STEP0: begin
										nxt.ncs = cls.eq;
										if (cls.qm || cls.eq) begin
											nxt.step   = STEP1;
											nxt.dstart = off;
										end
									end
									STEP1: begin
										if (cls.gt) begin
											end_region = 1'b1;
										end else if (cls.qm) begin
											nxt.step = STEP2;
										end else begin
											nxt.step = STEP0;
										end
									end
									STEP2: begin
										if (cls.gt) begin
											end_region = 1'b1;
										end
									end
									default: begin
										nxt.step = STEP0;
									end
								endcase
								if (end_region) begin
									if (nxt.dstart > st_q.rstart) begin
										emit    = 1'b1;
										e_kind  = KIND_CODE;
										e_end   = nxt.dstart;
										e_scope = nxt.brace;
										e_qp    = st_q.quick;
									end
									nxt.rstart = off_inc;
									nxt.code   = 1'b0;
									nxt.skip   = 1'b1;
									nxt.quick  = 1'b0;
									nxt.step   = STEP0;
								end
							end else if (!st_q.cms) begin
								if (cls.star) begin
									nxt.cms = 1'b1;
								end
							end else begin
								if (cls.slash) begin
									nxt.blk = 1'b0;
								end
								nxt.cms = 1'b0;
							end
						end
						if (!nxt.blk && cls.dquote) begin
							nxt.str = !st_q.str;
						end
					end
				end else begin
					case (st_q.step)
						STEP0: begin
							if (cls.lt) begin
								nxt.step   = STEP1;
								nxt.dstart = off;
							end
						end
						STEP1: begin
							nxt.step = cls.qm ? STEP2 : STEP0;
						end
						STEP2: begin
							if (cls.space || cls.eq) begin
								if (cls.eq) begin
									nxt.quick = 1'b1;
								end
								open_code = 1'b1;
							end
							nxt.step = cls.w ? STEP3 : STEP0;
						end
						STEP3: begin
							nxt.step = cls.c ? STEP4 : STEP0;
						end
						STEP4: begin
							open_code = cls.space;
							nxt.step  = STEP0;
						end
						default: begin
							nxt.step = STEP0;
						end
					endcase
					if (open_code) begin
						if (st_q.dstart > st_q.rstart) begin
							emit   = 1'b1;
							e_kind = st_q.ncs ? KIND_CSTR : KIND_ECHO;
						end
						nxt.rstart = off_inc;
						nxt.code   = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_RESET;
			blocks.valid <= 1'b0;
		end else begin
			if (adv) begin
				st_q <= nxt;
			end
			if (adv && emit) begin
				blocks.valid <= 1'b1;
			end else if (blocks.ready) begin
				blocks.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			blocks.block_kind  <= e_kind;
			blocks.block_start <= 32'(e_start);
			blocks.block_end   <= 32'(e_end);
			blocks.block_scope <= 16'(e_scope);
			blocks.quick_print <= e_qp;
		end
	end

	a_html_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.code |-> (!st_q.line && !st_q.blk && !st_q.str))
		else $error("comment or string state left over in HTML mode");

	a_one_comment: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_q.line && st_q.blk))
		else $error("line and block comment open together");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.step <= STEP4)
		else $error("matcher step out of range");

	a_emit_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && emit) |=> blocks.valid)
		else $error("record lost at output register");
endmodule

[src/template_delimiter_scanner.sv]
// An accepted byte is registered in the queue, and its record then reaches blocks through the output register.
// Throughput: one item per cycle while the queue is not full; the scanner state
// in the back end steps once per byte, and the four-entry queue absorbs output stalls.
// Reset: arst_n clears the offset counter, the queue, the scanner state and the
// output valid at once; no clearing pass is needed.
module template_delimiter_scanner #(
	parameter int OFFSET_BITS = 32,
	parameter int DEPTH_BITS  = 16
) (
	input logic         clk,
	input logic         arst_n,
	tds_byte_if.sink    bytes,
	tds_block_if.source blocks
);
	import tds_pkg::*;

	localparam int QW = 1 + $bits(cls_t) + OFFSET_BITS;

	logic                   push;
	logic                   full;
	logic                   f_cmd;
	cls_t                   f_cls;
	logic [OFFSET_BITS-1:0] f_off;
	logic                   q_valid;
	logic                   q_pop;
	logic [QW-1:0]          q_data;
	logic                   b_cmd;
	cls_t                   b_cls;
	logic [OFFSET_BITS-1:0] b_off;

	tds_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes),
		.full   (full),
		.push   (push),
		.cmd    (f_cmd),
		.cls    (f_cls),
		.off    (f_off)
	);

	tds_queue #(.WIDTH(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({f_cmd, f_cls, f_off}),
		.full   (full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_data)
	);

	assign {b_cmd, b_cls, b_off} = q_data;

	tds_back #(.OFFSET_BITS(OFFSET_BITS), .DEPTH_BITS(DEPTH_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (q_valid),
		.cmd    (b_cmd),
		.cls    (b_cls),
		.off    (b_off),
		.pop    (q_pop),
		.blocks (blocks)
	);
endmodule
